// ===== rtl/tcc_pkg.sv =====
`default_nettype none

package tcc_pkg;

  // operating mode codes, code 3 acts as off
  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_HEAT = 2'd1,
    MODE_COOL = 2'd2
  } mode_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_SETPOINT  = 3'd0,
    CFG_HYST      = 3'd1,
    CFG_ABS_MAX   = 3'd2,
    CFG_ABS_MIN   = 3'd3,
    CFG_MODE      = 3'd4,
    CFG_MIN_CYCLE = 3'd5,
    CFG_MAX_CYCLE = 3'd6
  } cfg_idx_e;

  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned HystWidth   = 10;
  localparam int unsigned SecWidth    = 16;

  // 2 degree margin beyond the absolute limits, 1/16 degree units
  localparam int LimitMargin = 32;

  // reset values
  localparam int ResetSetpoint  = 320;
  localparam int ResetHyst      = 16;
  localparam int ResetAbsMax    = 480;
  localparam int ResetAbsMin    = 160;
  localparam int ResetMinCycle  = 300;
  localparam int ResetMaxCycle  = 3600;

endpackage

`default_nettype wire

// ===== rtl/thermostat_cycle_controller.sv =====
// thermostat cycle controller
// input channel (in_valid_i/in_ready_o) carries one evaluation: a temperature
// sample in 1/16 degree and the seconds since the cycle interval restarted.
// output channel (out_valid_o/out_ready_i) returns one result per evaluation:
// heat relay, cool relay and whether the cycle interval must restart.
// configuration channel (cfg_valid_i/cfg_ready_o) writes register cfg_index_i
// with cfg_data_i; it is always ready and should only be used while idle.
// the result is registered: it is valid in the cycle after the input transfer.
// throughput: one evaluation per cycle while the receiver keeps up; the
// decision is a few compares on the registered state and the incoming sample,
// written straight into the result register together with the updated state.
// when the receiver stalls, the result is held and one more input is
// taken only once the result register frees up (same cycle as its transfer).
// reset: setpoint 320, hysteresis 16, limits 480/160, mode off, min cycle 300 s,
// max cycle 3600 s, demand and relays off, first call pending, no result.
`default_nettype none

module thermostat_cycle_controller #(
  parameter int unsigned TEMP_WIDTH = 12
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration write
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [tcc_pkg::CfgIdxWidth-1:0]   cfg_index_i,
  input  wire logic [((TEMP_WIDTH > tcc_pkg::SecWidth) ?
                      TEMP_WIDTH : tcc_pkg::SecWidth)-1:0] cfg_data_i,
  // evaluation input
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic signed [TEMP_WIDTH-1:0]      temperature_i,
  input  wire logic [tcc_pkg::SecWidth-1:0]      elapsed_seconds_i,
  // result output
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic                                   heat_on_o,
  output logic                                   cool_on_o,
  output logic                                   restart_interval_o
);
  import tcc_pkg::*;

  // compare width: doubled temperature plus or minus the hysteresis
  localparam int unsigned CmpWidth =
    ((TEMP_WIDTH > HystWidth) ? TEMP_WIDTH : HystWidth) + 2;

  // configuration registers
  logic signed [TEMP_WIDTH-1:0] setpoint_q, abs_max_q, abs_min_q;
  logic [HystWidth-1:0]         hyst_q;
  logic [1:0]                   mode_q;
  logic [SecWidth-1:0]          min_cycle_q, max_cycle_q;

  // controller state
  logic demand_q, demand_d;
  logic first_call_q, first_call_d;
  logic heat_q, heat_d;
  logic cool_q, cool_d;

  // result register
  logic out_valid_q;
  logic heat_on_q, cool_on_q, restart_q;
  logic restart_d;

  logic in_fire, out_fire;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_q && out_ready_i;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q  <= TEMP_WIDTH'(ResetSetpoint);
      hyst_q      <= HystWidth'(ResetHyst);
      abs_max_q   <= TEMP_WIDTH'(ResetAbsMax);
      abs_min_q   <= TEMP_WIDTH'(ResetAbsMin);
      mode_q      <= MODE_OFF;
      min_cycle_q <= SecWidth'(ResetMinCycle);
      max_cycle_q <= SecWidth'(ResetMaxCycle);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_SETPOINT:  setpoint_q  <= cfg_data_i[TEMP_WIDTH-1:0];
        CFG_HYST:      hyst_q      <= cfg_data_i[HystWidth-1:0];
        CFG_ABS_MAX:   abs_max_q   <= cfg_data_i[TEMP_WIDTH-1:0];
        CFG_ABS_MIN:   abs_min_q   <= cfg_data_i[TEMP_WIDTH-1:0];
        CFG_MODE:      mode_q      <= cfg_data_i[1:0];
        CFG_MIN_CYCLE: min_cycle_q <= cfg_data_i[SecWidth-1:0];
        CFG_MAX_CYCLE: max_cycle_q <= cfg_data_i[SecWidth-1:0];
        default: ;
      endcase
    end
  end

  // widened operands
  logic signed [CmpWidth-1:0] temp_x, temp2, sp2, hyst_x;
  logic signed [CmpWidth-1:0] amax_lim, amin_lim, heat_target, cool_target;
  logic [SecWidth-1:0]        min_cycle;
  logic                       is_heat, is_cool, max_run, cycle_ok;

  assign temp_x   = CmpWidth'(temperature_i);
  assign temp2    = temp_x <<< 1;
  assign sp2      = CmpWidth'(setpoint_q) <<< 1;
  assign hyst_x   = CmpWidth'($unsigned(hyst_q));
  assign amax_lim = CmpWidth'(abs_max_q) + CmpWidth'(LimitMargin);
  assign amin_lim = CmpWidth'(abs_min_q) - CmpWidth'(LimitMargin);

  // band edges move with demand
  assign heat_target = demand_q ? (sp2 + hyst_x) : (sp2 - hyst_x);
  assign cool_target = demand_q ? (sp2 - hyst_x) : (sp2 + hyst_x);

  // minimum cycle halved while running
  assign min_cycle = demand_q ? (min_cycle_q >> 1) : min_cycle_q;
  assign cycle_ok  = first_call_q || (elapsed_seconds_i >= min_cycle);
  assign max_run   = demand_q && (elapsed_seconds_i >= max_cycle_q);
  assign is_heat   = (mode_q == MODE_HEAT);
  assign is_cool   = (mode_q == MODE_COOL);

  // decision logic
  always_comb begin
    demand_d     = demand_q;
    first_call_d = first_call_q;
    heat_d       = heat_q;
    cool_d       = cool_q;
    restart_d    = 1'b0;
    priority if (max_run) begin
      restart_d = 1'b1;
      demand_d  = 1'b0;
      if (is_cool) begin
        cool_d = 1'b0;
      end else begin
        heat_d = 1'b0;
      end
    end else if (is_cool && (temp_x < amin_lim)) begin
      restart_d = demand_q;
      demand_d  = 1'b0;
      cool_d    = 1'b0;
    end else if (is_heat && (temp_x > amax_lim)) begin
      restart_d = demand_q;
      demand_d  = 1'b0;
      heat_d    = 1'b0;
    end else if (is_cool) begin
      if (cycle_ok) begin
        if (temp2 > cool_target) begin
          first_call_d = 1'b0;
          restart_d    = !demand_q;
          demand_d     = 1'b1;
          cool_d       = 1'b1;
        end else begin
          restart_d = demand_q;
          demand_d  = 1'b0;
          cool_d    = 1'b0;
        end
      end
    end else if (is_heat) begin
      if (cycle_ok) begin
        if (temp2 < heat_target) begin
          first_call_d = 1'b0;
          restart_d    = !demand_q;
          demand_d     = 1'b1;
          heat_d       = 1'b1;
        end else begin
          restart_d = demand_q;
          demand_d  = 1'b0;
          heat_d    = 1'b0;
        end
      end
    end else begin
      restart_d = 1'b0;
    end
  end

  // state update on input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      demand_q     <= 1'b0;
      first_call_q <= 1'b1;
      heat_q       <= 1'b0;
      cool_q       <= 1'b0;
    end else if (in_fire) begin
      demand_q     <= demand_d;
      first_call_q <= first_call_d;
      heat_q       <= heat_d;
      cool_q       <= cool_d;
    end
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      heat_on_q <= heat_d;
      cool_on_q <= cool_d;
      restart_q <= restart_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign heat_on_o          = heat_on_q;
  assign cool_on_o          = cool_on_q;
  assign restart_interval_o = restart_q;

  // a running call always has cleared the first call flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    demand_q |-> !first_call_q)
    else $error("demand on while first call still pending");

  // a transfer always leaves a result behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("input transfer without result");

  // restart flag reports a demand change
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (restart_q == (demand_q != $past(demand_q))))
    else $error("restart flag does not match demand change");

  // result relays mirror the state after the step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> ((heat_on_q == heat_q) && (cool_on_q == cool_q)))
    else $error("result relays differ from relay state");

  // state moves only on an input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> ($stable(demand_q) && $stable(heat_q) && $stable(cool_q)
                  && $stable(first_call_q)))
    else $error("state changed without an input transfer");

endmodule

`default_nettype wire

// ===== tb/thermostat_cycle_controller_tb.sv =====
`default_nettype none

module thermostat_cycle_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcc_pkg::*;

  localparam int CycleLimit = 300000;
  // mode code 3 has no name in the package and acts as off
  localparam logic [1:0] ModeUnused = 2'd3;

  typedef struct packed {
    logic heat;
    logic cool;
    logic restart;
  } relay_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxWidth-1:0] cfg_index_i = '0;
  logic [SecWidth-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [11:0] temperature_i = '0;
  logic [SecWidth-1:0] elapsed_seconds_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic heat_on_o;
  logic cool_on_o;
  logic restart_interval_o;

  thermostat_cycle_controller u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .temperature_i      (temperature_i),
    .elapsed_seconds_i  (elapsed_seconds_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .heat_on_o          (heat_on_o),
    .cool_on_o          (cool_on_o),
    .restart_interval_o (restart_interval_o)
  );

  // register copies for prediction
  logic signed [11:0] setpoint_q = 12'sd320;
  logic [HystWidth-1:0] hyst_q = 10'd16;
  logic signed [11:0] abs_max_q = 12'sd480;
  logic signed [11:0] abs_min_q = 12'sd160;
  logic [1:0] mode_q = MODE_OFF;
  logic [SecWidth-1:0] min_cycle_q = 16'd300;
  logic [SecWidth-1:0] max_cycle_q = 16'd3600;

  // thermostat state copies
  logic demand_q = 1'b0;
  logic first_call_q = 1'b1;
  logic heat_relay_q = 1'b0;
  logic cool_relay_q = 1'b0;

  relay_result_t expected_relays[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count = 0;
  int eval_count = 0;
  int restart_count = 0;
  int heat_count = 0;
  int cool_count = 0;
  int write_count = 0;
  int cycle_count = 0;

  // clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver stalls
  always @(posedge clk_i) begin
    out_ready_i <= (int'($urandom_range(99)) >= recv_idle_pct);
  end

  function automatic logic switch_cool(input logic on);
    logic changed;
    changed = (demand_q != on);
    demand_q = on;
    cool_relay_q = on;
    return changed;
  endfunction

  function automatic logic switch_heat(input logic on);
    logic changed;
    changed = (demand_q != on);
    demand_q = on;
    heat_relay_q = on;
    return changed;
  endfunction

  // one thermostat evaluation on the state copies
  function automatic relay_result_t evaluate_sample(input logic signed [11:0] temp,
                                                    input logic [SecWidth-1:0] elapsed);
    int temp2;
    int sp2;
    int hyst;
    int target2;
    logic [SecWidth-1:0] min_cycle;
    logic changed;
    relay_result_t res;
    temp2 = 2 * int'(temp);
    sp2 = 2 * int'(setpoint_q);
    hyst = int'(hyst_q);
    min_cycle = demand_q ? (min_cycle_q >> 1) : min_cycle_q;
    changed = 1'b0;
    if (demand_q && elapsed >= max_cycle_q) begin
      if (mode_q == MODE_COOL) changed = switch_cool(1'b0);
      else changed = switch_heat(1'b0);
    end else if (mode_q == MODE_COOL && int'(temp) < int'(abs_min_q) - LimitMargin) begin
      changed = switch_cool(1'b0);
    end else if (mode_q == MODE_HEAT && int'(temp) > int'(abs_max_q) + LimitMargin) begin
      changed = switch_heat(1'b0);
    end else if (mode_q == MODE_COOL) begin
      target2 = demand_q ? sp2 - hyst : sp2 + hyst;
      if (first_call_q || elapsed >= min_cycle) begin
        if (temp2 > target2) begin
          first_call_q = 1'b0;
          changed = switch_cool(1'b1);
        end else begin
          changed = switch_cool(1'b0);
        end
      end
    end else if (mode_q == MODE_HEAT) begin
      target2 = demand_q ? sp2 + hyst : sp2 - hyst;
      if (first_call_q || elapsed >= min_cycle) begin
        if (temp2 < target2) begin
          first_call_q = 1'b0;
          changed = switch_heat(1'b1);
        end else begin
          changed = switch_heat(1'b0);
        end
      end
    end
    res.heat = heat_relay_q;
    res.cool = cool_relay_q;
    res.restart = changed;
    return res;
  endfunction

  // result check, register tracking and prediction at each edge
  always @(posedge clk_i) begin : monitor
    relay_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_relays.size() == 0) begin
          $error("result transfer with no evaluation pending");
          fail_count++;
        end else begin
          want = expected_relays.pop_front();
          if (heat_on_o !== want.heat) begin
            $error("heat_on: expected %0b, got %0b", want.heat, heat_on_o);
            fail_count++;
          end
          if (cool_on_o !== want.cool) begin
            $error("cool_on: expected %0b, got %0b", want.cool, cool_on_o);
            fail_count++;
          end
          if (restart_interval_o !== want.restart) begin
            $error("restart_interval: expected %0b, got %0b", want.restart,
                   restart_interval_o);
            fail_count++;
          end
          restart_count += want.restart;
          heat_count += want.heat;
          cool_count += want.cool;
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        write_count++;
        case (cfg_idx_e'(cfg_index_i))
          CFG_SETPOINT:  setpoint_q = cfg_data_i[11:0];
          CFG_HYST:      hyst_q = cfg_data_i[HystWidth-1:0];
          CFG_ABS_MAX:   abs_max_q = cfg_data_i[11:0];
          CFG_ABS_MIN:   abs_min_q = cfg_data_i[11:0];
          CFG_MODE:      mode_q = cfg_data_i[1:0];
          CFG_MIN_CYCLE: min_cycle_q = cfg_data_i;
          CFG_MAX_CYCLE: max_cycle_q = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        expected_relays.push_back(evaluate_sample(temperature_i, elapsed_seconds_i));
        eval_count++;
      end
    end
  end

  // one evaluation transfer, valid is left high for a following item
  task automatic send_eval(input int temp, input int elapsed);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    temperature_i <= 12'(temp);
    elapsed_seconds_i <= 16'(elapsed);
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // stop sending and wait for every pending result
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_relays.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // register write, only while idle
  task automatic write_reg(input cfg_idx_e idx, input int value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= 16'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_power_up();
    // mode off after reset, nothing switches
    send_eval(-2048, 0);
    send_eval(2047, 65535);
    drain_results();
  endtask

  task automatic test_heat_cycle();
    write_reg(CFG_MODE, MODE_HEAT);
    // first call ignores the minimum cycle time
    send_eval(300, 0);
    // postponed, then switched off past the upper band edge
    send_eval(330, 10);
    send_eval(330, 150);
    send_eval(300, 299);
    send_eval(300, 300);
    // max run reached
    send_eval(300, 3600);
    // beyond the upper absolute limit
    send_eval(600, 65535);
    drain_results();
  endtask

  task automatic test_cool_and_mode_change();
    send_eval(300, 65535);
    drain_results();
    // heat relay keeps its state while cool mode runs
    write_reg(CFG_MODE, MODE_COOL);
    send_eval(340, 0);
    send_eval(400, 150);
    send_eval(100, 65535);
    send_eval(100, 200);
    drain_results();
    write_reg(CFG_MODE, ModeUnused);
    send_eval(400, 0);
    drain_results();
    write_reg(CFG_MODE, MODE_OFF);
    send_eval(400, 65535);
    drain_results();
  endtask

  task automatic test_config_extremes();
    write_reg(CFG_SETPOINT, 2047);
    write_reg(CFG_HYST, 1023);
    write_reg(CFG_ABS_MAX, -2048);
    write_reg(CFG_ABS_MIN, 2047);
    write_reg(CFG_MIN_CYCLE, 65535);
    write_reg(CFG_MAX_CYCLE, 65535);
    write_reg(CFG_MODE, MODE_HEAT);
    send_eval(2047, 65535);
    drain_results();
    write_reg(CFG_MODE, MODE_COOL);
    send_eval(-2048, 65534);
    drain_results();
    write_reg(CFG_SETPOINT, -2048);
    write_reg(CFG_HYST, 0);
    write_reg(CFG_ABS_MAX, 2047);
    write_reg(CFG_ABS_MIN, -2048);
    write_reg(CFG_MIN_CYCLE, 0);
    write_reg(CFG_MAX_CYCLE, 0);
    send_eval(-2047, 0);
    send_eval(-2048, 0);
    drain_results();
  endtask

  // new register set, biased toward usable control but with extremes
  task automatic pick_config();
    int sp;
    int pick;
    sp = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 2047 : -2048)
                                  : int'($urandom_range(1000)) - 300;
    write_reg(CFG_SETPOINT, sp);
    pick = $urandom_range(9);
    write_reg(CFG_HYST, (pick == 0) ? 1023 : (pick == 1) ? 0 : int'($urandom_range(48)));
    pick = $urandom_range(9);
    write_reg(CFG_ABS_MAX, (pick == 0) ? -2048 : (pick == 1) ? 2047
                           : sp + int'($urandom_range(200)));
    pick = $urandom_range(9);
    write_reg(CFG_ABS_MIN, (pick == 0) ? 2047 : (pick == 1) ? -2048
                           : sp - int'($urandom_range(200)));
    pick = $urandom_range(9);
    write_reg(CFG_MODE, (pick == 0) ? MODE_OFF : (pick == 1) ? ModeUnused
                        : (pick < 6) ? MODE_HEAT : MODE_COOL);
    pick = $urandom_range(9);
    write_reg(CFG_MIN_CYCLE, (pick == 0) ? 0 : (pick == 1) ? 65535
                             : int'($urandom_range(400)));
    pick = $urandom_range(9);
    write_reg(CFG_MAX_CYCLE, (pick == 0) ? 0 : (pick == 1) ? 65535
                             : int'(min_cycle_q) + int'($urandom_range(2000)));
  endtask

  // one sample aimed at the band edges, the limits and the cycle thresholds
  task automatic send_random();
    int span;
    int temp;
    int elapsed;
    int pick;
    span = int'(hyst_q) / 2 + 4;
    pick = $urandom_range(9);
    if (pick < 2) temp = $urandom_range(4095);
    else if (pick < 7) temp = int'(setpoint_q) + int'($urandom_range(2 * span)) - span;
    else if (pick < 9) temp = int'(abs_max_q) + LimitMargin + int'($urandom_range(6)) - 3;
    else temp = int'(abs_min_q) - LimitMargin + int'($urandom_range(6)) - 3;
    pick = $urandom_range(9);
    if (pick < 3) elapsed = $urandom_range(65535);
    else if (pick < 6) elapsed = int'($urandom_range(1) ? min_cycle_q : min_cycle_q >> 1)
                                 + int'($urandom_range(4)) - 2;
    else if (pick < 8) elapsed = int'(max_cycle_q) + int'($urandom_range(4)) - 2;
    else elapsed = $urandom_range(int'(min_cycle_q));
    send_eval(temp, elapsed);
  endtask

  task automatic test_random(input int count);
    int left;
    int chunk;
    left = count;
    while (left > 0) begin
      chunk = $urandom_range(20, 60);
      if (chunk > left) chunk = left;
      drain_results();
      pick_config();
      repeat (chunk) send_random();
      left -= chunk;
    end
    drain_results();
  endtask

  // test sequence
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 38;
    recv_idle_pct = 71;
    test_power_up();
    test_heat_cycle();
    test_cool_and_mode_change();
    test_config_extremes();
    test_random(230);
    send_idle_pct = 71;
    recv_idle_pct = 38;
    test_random(230);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(240);
    repeat (5) @(posedge clk_i);
    $display("run covered %0d evaluations and %0d register writes under three stall mixes",
             eval_count, write_count);
    $display("results seen: %0d interval restarts, %0d with heat on, %0d with cool on",
             restart_count, heat_count, cool_count);
    if (fail_count == 0 && expected_relays.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
